@@ design/rmv_pkg.sv @@
// Package for the running mean and variance core.
// Holds the fixed field widths, parameter defaults, limits and the sequencer state type.
// No dependencies; used by running_mean_variance_core and its checker.
package rmv_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_FRAC_BITS    = 16;
   localparam int DEF_COUNT_WIDTH  = 32;

   // Fixed result field widths.
   localparam int COUNT_OUT_W = 32;
   localparam int MEAN_W      = 32;
   localparam int VAR_W       = 47;
   localparam int SIGMA_W     = 24;
   localparam int RSP_DW      = 136;   // 135 bits of fields padded to whole bytes

   // The deviation magnitude is clamped to this many bits before squaring.
   localparam int MAG_W = 32;

   // Square root: radicand padded to an even width, one result bit per step.
   localparam int SQ_IN_W = 48;
   localparam int ROOT_W  = SQ_IN_W / 2;

   // Saturation limits.
   localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
   localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};
   localparam logic [VAR_W-1:0]         VAR_MAX  = {VAR_W{1'b1}};
   localparam logic [MAG_W-1:0]         MAG_MAX  = {MAG_W{1'b1}};

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,    // waiting for a sample
      ST_MDIV,    // serial divide for the mean step
      ST_MEAN,    // apply and saturate the mean step
      ST_DEV,     // deviation from the new mean
      ST_MUL,     // serial square of the deviation
      ST_TLOAD,   // set up the divide of the square by n-1
      ST_TDIV,    // serial divide of the square
      ST_VLOAD,   // set up the divide of the variance by n
      ST_VDIV,    // serial divide of the variance
      ST_VSUM,    // combine and clamp the new variance
      ST_SLOAD,   // set up the square root
      ST_SQRT,    // serial square root
      ST_DONE     // hand the result word to the output register
   } state_type;

endpackage

@@ design/running_mean_variance_core.sv @@
// Running mean and population variance core (Welford update), top level.
// Depends on rmv_pkg; the serial arithmetic runs on one shared bit-serial divider,
// a shift-add multiplier and a two-bit-per-step square root.
//
// Usage:
//   The req_ channel takes one word per sample: a signed integer in the low
//   SAMPLE_WIDTH bits of req_tdata. For every sample the rsp_ channel returns one
//   word with the saturating count, the mean (16 fraction bits by default), the
//   population variance (same fraction bits) and sigma, the floor of the square
//   root of the variance field.
//   Sequencing: one sample is processed at a time. The divider is DIV_W bits
//   wide (49 at default parameters). A full update runs three serial divides
//   through the single restoring divider, 32 multiplier steps and 24 square
//   root steps; the very first sample after reset skips the variance update.
//   Stalls: the finished word waits in an output register; a new sample is
//   accepted while it waits, and the sequencer only holds in its final state if
//   the next result is ready before the previous one has been taken.
//   Reset: the synchronous reset clears the count, mean and variance to zero
//   and drops rsp_tvalid.
module running_mean_variance_core #(
   parameter int SAMPLE_WIDTH = rmv_pkg::DEF_SAMPLE_WIDTH,
   parameter int FRAC_BITS    = rmv_pkg::DEF_FRAC_BITS,
   parameter int COUNT_WIDTH  = rmv_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample input channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,   // sample, zero padding
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rmv_pkg::RSP_DW-1:0]           rsp_tdata    // count, mean, variance,
                                                             // sigma, zero padding
);
   import rmv_pkg::*;

   // Derived widths.
   localparam int XQ_W    = SAMPLE_WIDTH + FRAC_BITS;
   localparam int DEV_M   = (XQ_W > MEAN_W) ? XQ_W : MEAN_W;
   localparam int DEV_W   = DEV_M + 2;
   localparam int SQ_W    = 2 * MAG_W - FRAC_BITS;
   localparam int DIV_A   = (DEV_W - 1 > SQ_W + 1) ? DEV_W - 1 : SQ_W + 1;
   localparam int DIV_W   = (DIV_A > VAR_W + 1) ? DIV_A : VAR_W + 1;
   localparam int MSUM_W  = DEV_W + 1;
   localparam int SUM_W   = DIV_W + 2;
   localparam int STEP_W  = $clog2(DIV_W + 1);
   localparam int SCUR_W  = ROOT_W + 4;

   // Sequencer and statistics registers.
   state_type                 state_ff, state_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic signed [MEAN_W-1:0]  mean_ff, mean_in;
   logic [VAR_W-1:0]          var_ff, var_in;
   logic signed [XQ_W-1:0]    xq_ff, xq_in;
   logic [STEP_W-1:0]         step_ff, step_in;

   // Divider registers.
   logic                      neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0]    div_ff, div_in;
   logic [COUNT_WIDTH-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]          quo_ff, quo_in;
   logic [DIV_W-1:0]          term_ff, term_in;

   // Multiplier and square root registers.
   logic [2*MAG_W-1:0]        prod_ff, prod_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [SQ_IN_W-1:0]        sqv_ff, sqv_in;
   logic [ROOT_W+1:0]         srem_ff, srem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]         rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                      count_sat;
   logic [COUNT_WIDTH-1:0]    n_next;
   logic signed [XQ_W-1:0]    xq_new;
   logic signed [DEV_W-1:0]   d_new;
   logic [DEV_W-1:0]          d_mag;
   logic [COUNT_WIDTH:0]      div_shift;
   logic [COUNT_WIDTH:0]      div_diff;
   logic                      div_ge;
   logic                      last_div;
   logic signed [MSUM_W-1:0]  q_ext;
   logic signed [MSUM_W-1:0]  msum;
   logic [MSUM_W-MEAN_W:0]    msum_hi;
   logic signed [DEV_W-1:0]   dev;
   logic [DEV_W-1:0]          dev_mag;
   logic [MAG_W:0]            mul_sum;
   logic [COUNT_WIDTH-1:0]    n_less;
   logic signed [SUM_W-1:0]   vsum;
   logic [SCUR_W-1:0]         s_cur;
   logic [SCUR_W-1:0]         s_trial;
   logic                      s_ge;

   // Count update and first divide operand for an incoming sample.
   assign count_sat = &count_ff;
   assign n_next    = count_sat ? count_ff : count_ff + 1'b1;
   assign xq_new    = $signed({req_tdata[SAMPLE_WIDTH-1:0], {FRAC_BITS{1'b0}}});
   assign d_new     = DEV_W'(xq_new) - DEV_W'(mean_ff);
   assign d_mag     = d_new[DEV_W-1] ? DEV_W'(-d_new) : DEV_W'(d_new);

   // One restoring divide step: shift in the next dividend bit, trial subtract.
   assign div_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge    = div_shift >= {1'b0, div_ff};
   assign div_diff  = div_shift - {1'b0, div_ff};
   assign last_div  = step_ff == STEP_W'(DIV_W - 1);

   // Mean step with saturation to the signed mean range.
   assign q_ext   = $signed({2'b00, quo_ff[DEV_W-2:0]});
   assign msum    = MSUM_W'(mean_ff) + (neg_ff ? -q_ext : q_ext);
   assign msum_hi = msum[MSUM_W-1:MEAN_W-1];

   // Deviation from the new mean, magnitude clamped before squaring.
   assign dev     = DEV_W'(xq_ff) - DEV_W'(mean_ff);
   assign dev_mag = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);

   // Shift-add multiplier step.
   assign mul_sum = {1'b0, prod_ff[2*MAG_W-1:MAG_W]} + (prod_ff[0] ? {1'b0, mag_ff} : '0);

   // Divisor for the squared deviation, and the combined variance.
   assign n_less = count_ff - 1'b1;
   assign vsum   = $signed(SUM_W'(var_ff)) + $signed(SUM_W'(term_ff))
                   - $signed(SUM_W'(quo_ff));

   // Square root step: bring down two bits, trial subtract 4*root + 1.
   assign s_cur   = {srem_ff, sqv_ff[SQ_IN_W-1 -: 2]};
   assign s_trial = SCUR_W'({root_ff, 2'b01});
   assign s_ge    = s_cur >= s_trial;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_MDIV;
         ST_MDIV:  if (last_div) state_in = ST_MEAN;
         ST_MEAN:  state_in = (count_ff == COUNT_WIDTH'(1)) ? ST_SLOAD : ST_DEV;
         ST_DEV:   state_in = ST_MUL;
         ST_MUL:   if (step_ff == STEP_W'(MAG_W - 1)) state_in = ST_TLOAD;
         ST_TLOAD: state_in = ST_TDIV;
         ST_TDIV:  if (last_div) state_in = ST_VLOAD;
         ST_VLOAD: state_in = ST_VDIV;
         ST_VDIV:  if (last_div) state_in = ST_VSUM;
         ST_VSUM:  state_in = ST_SLOAD;
         ST_SLOAD: state_in = ST_SQRT;
         ST_SQRT:  if (step_ff == STEP_W'(ROOT_W - 1)) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and handshake outputs for each state.
   always_comb begin
      count_in     = count_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      xq_in        = xq_ff;
      neg_in       = neg_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      term_in      = term_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      sqv_in       = sqv_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      step_in      = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               count_in = n_next;
               xq_in    = xq_new;
               neg_in   = d_new[DEV_W-1];
               div_in   = n_next;
               rem_in   = '0;
               quo_in   = DIV_W'(d_mag) + DIV_W'(n_next >> 1);
            end
         end
         ST_MDIV, ST_TDIV, ST_VDIV: begin
            rem_in  = div_ge ? div_diff[COUNT_WIDTH-1:0] : div_shift[COUNT_WIDTH-1:0];
            quo_in  = {quo_ff[DIV_W-2:0], div_ge};
            step_in = last_div ? '0 : step_ff + 1'b1;
         end
         ST_MEAN: begin
            if ((&msum_hi) || !(|msum_hi)) begin
               mean_in = msum[MEAN_W-1:0];
            end else begin
               mean_in = msum[MSUM_W-1] ? MEAN_MIN : MEAN_MAX;
            end
         end
         ST_DEV: begin
            mag_in  = (|dev_mag[DEV_W-1:MAG_W]) ? MAG_MAX : dev_mag[MAG_W-1:0];
            prod_in = {{MAG_W{1'b0}},
                       (|dev_mag[DEV_W-1:MAG_W]) ? MAG_MAX : dev_mag[MAG_W-1:0]};
         end
         ST_MUL: begin
            prod_in = {mul_sum, prod_ff[MAG_W-1:1]};
            step_in = (step_ff == STEP_W'(MAG_W - 1)) ? '0 : step_ff + 1'b1;
         end
         ST_TLOAD: begin
            div_in = n_less;
            rem_in = '0;
            quo_in = DIV_W'(prod_ff[2*MAG_W-1:FRAC_BITS]) + DIV_W'(n_less >> 1);
         end
         ST_VLOAD: begin
            term_in = quo_ff;
            div_in  = count_ff;
            rem_in  = '0;
            quo_in  = DIV_W'(var_ff) + DIV_W'(count_ff >> 1);
         end
         ST_VSUM: begin
            if (vsum[SUM_W-1]) begin
               var_in = '0;
            end else if (|vsum[SUM_W-2:VAR_W]) begin
               var_in = VAR_MAX;
            end else begin
               var_in = vsum[VAR_W-1:0];
            end
         end
         ST_SLOAD: begin
            sqv_in  = SQ_IN_W'(var_ff);
            srem_in = '0;
            root_in = '0;
         end
         ST_SQRT: begin
            sqv_in  = sqv_ff << 2;
            srem_in = s_ge ? (ROOT_W+2)'(s_cur - s_trial) : (ROOT_W+2)'(s_cur);
            root_in = {root_ff[ROOT_W-2:0], s_ge};
            step_in = (step_ff == STEP_W'(ROOT_W - 1)) ? '0 : step_ff + 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, root_ff, var_ff, mean_ff, COUNT_OUT_W'(count_ff)};
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   // Control state and statistics, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         var_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the serial units and the output word.
   always_ff @(posedge clock) begin
      xq_ff       <= xq_in;
      neg_ff      <= neg_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      term_ff     <= term_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
      sqv_ff      <= sqv_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/rmv_checker.sv @@
// Port-level checker for running_mean_variance_core, attached by a bind.
// Depends on rmv_pkg for the result field widths.
// Checks output holding, reset behavior, one-at-a-time intake, first-sample zeros and sigma consistency.
module rmv_checker #(
   parameter int SAMPLE_WIDTH = rmv_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [rmv_pkg::RSP_DW-1:0]           rsp_tdata
);
   import rmv_pkg::*;

   logic [COUNT_OUT_W-1:0] f_count;
   logic [VAR_W-1:0]       f_var;
   logic [SIGMA_W-1:0]     f_sigma;
   logic [2*SIGMA_W+1:0]   sig_sq;
   logic [2*SIGMA_W+1:0]   sig_up_sq;
   logic                   req_seen;

   // Unpack the result word.
   assign f_count   = rsp_tdata[COUNT_OUT_W-1:0];
   assign f_var     = rsp_tdata[COUNT_OUT_W+MEAN_W+VAR_W-1:COUNT_OUT_W+MEAN_W];
   assign f_sigma   = rsp_tdata[COUNT_OUT_W+MEAN_W+VAR_W+SIGMA_W-1:COUNT_OUT_W+MEAN_W+VAR_W];
   assign sig_sq    = (2*SIGMA_W+2)'(f_sigma) * (2*SIGMA_W+2)'(f_sigma);
   assign sig_up_sq = ((2*SIGMA_W+2)'(f_sigma) + 1'b1) * ((2*SIGMA_W+2)'(f_sigma) + 1'b1);
   assign req_seen  = req_tvalid & req_tready & (|req_tdata | ~|req_tdata);

   // A stalled result word stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // Reset removes any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A sample is worked on alone: intake closes right after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("second sample taken while one is in progress");

   // The first sample leaves variance and sigma at zero.
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && f_count == COUNT_OUT_W'(1) |-> f_var == '0 && f_sigma == '0)
      else $error("nonzero variance after the first sample");

   // Sigma is the floor of the square root of the variance field.
   a_sigma_root: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> sig_sq <= (2*SIGMA_W+2)'(f_var) && sig_up_sq > (2*SIGMA_W+2)'(f_var))
      else $error("sigma does not match the variance");

endmodule

bind running_mean_variance_core rmv_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_rmv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
